// ----- hdl/block_rms_signal_detector_unit_defines.svh -----
// Assertion macros shared by the block RMS signal detector RTL.
`ifndef BLOCK_RMS_SIGNAL_DETECTOR_UNIT_DEFINES_SVH
`define BLOCK_RMS_SIGNAL_DETECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a property holds on every rising clock edge outside reset.
`define BRSD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check that a condition in one cycle implies a consequence in the next.
`define BRSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BRSD_ASSERT(label, clk, rst, prop)
`define BRSD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/brsd_pkg.sv -----
// Types and constants shared by the block RMS signal detector.
`timescale 1ns / 1ps
package brsd_pkg;

  localparam int MAX_BLOCK_SAMPLES = 4096;
  localparam int COUNT_W = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int SQ_W = 31;
  localparam int THR_W = 31;
  localparam int SUM_W = $clog2(MAX_BLOCK_SAMPLES) + SQ_W;
  localparam int PROD_W = THR_W + COUNT_W;
  localparam int MS_W = 16;
  localparam int TIME_W = 32;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_INDEX_W = 2;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DETECT_ENABLE = 2'd0,
    REG_THRESHOLD     = 2'd1,
    REG_ATTACK_MS     = 2'd2,
    REG_RELEASE_MS    = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic              detect_enable;
    logic [THR_W-1:0]  threshold_mean_square;
    logic [MS_W-1:0]   attack_ms;
    logic [MS_W-1:0]   release_ms;
  } cfg_t;

  // One evaluated block, handed from the front to the debounce back end.
  typedef struct packed {
    logic              above;
    logic [TIME_W-1:0] time_ms;
  } block_event_t;

  typedef struct packed {
    logic                  empty;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_status_t;

endpackage

// ----- hdl/brsd_if.sv -----
// Valid/ready channel interfaces for samples and detector results.
`timescale 1ns / 1ps
interface brsd_sample_if import brsd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [15:0]       sample;
  logic                     last_of_block;
  logic [TIME_W-1:0]        time_ms;

  modport source (output valid, sample, last_of_block, time_ms, input ready);
  modport sink (input valid, sample, last_of_block, time_ms, output ready);
endinterface

interface brsd_result_if;
  logic valid;
  logic ready;
  logic signal_present;
  logic signal_changed;
  logic level_above;

  modport source (output valid, signal_present, signal_changed, level_above, input ready);
  modport sink (input valid, signal_present, signal_changed, level_above, output ready);
endinterface

// ----- hdl/brsd_front.sv -----
// Front end: squares samples, sums blocks and compares against the threshold.
`timescale 1ns / 1ps
`include "block_rms_signal_detector_unit_defines.svh"
module brsd_front import brsd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  brsd_sample_if.sink      samples,
  input  fifo_status_t     fifo_status,
  output logic             push,
  output block_event_t     push_data
);

  // stage A: square and block counting
  logic                  a_valid;
  logic                  a_clear;
  logic                  a_end;
  logic [SQ_W-1:0]       a_sq;
  logic [COUNT_W-1:0]    a_count;
  logic [TIME_W-1:0]     a_time;
  logic [COUNT_W-1:0]    count;
  // stage B: accumulate and scale threshold
  logic [SUM_W-1:0]      acc;
  logic                  b_valid;
  logic [SUM_W-1:0]      b_sum;
  logic [PROD_W-1:0]     b_prod;
  logic [TIME_W-1:0]     b_time;
  // stage C: compare
  logic                  c_valid;
  logic                  c_above;
  logic [TIME_W-1:0]     c_time;

  logic                  accept;
  logic signed [31:0]    sq_full;
  logic [COUNT_W-1:0]    count_inc;
  logic                  block_end;
  logic [SUM_W-1:0]      acc_sum;
  logic [PROD_W-1:0]     prod;
  logic [FIFO_CNT_W-1:0] inflight;
  logic [FIFO_CNT_W-1:0] committed;

  assign accept    = samples.valid & samples.ready;
  assign sq_full   = samples.sample * samples.sample;
  assign count_inc = count + COUNT_W'(1);
  assign block_end = samples.last_of_block || (count_inc == COUNT_W'(MAX_BLOCK_SAMPLES));
  assign acc_sum   = acc + SUM_W'(a_sq);
  assign prod      = PROD_W'(cfg.threshold_mean_square) * PROD_W'(a_count);

  // reserve a queue slot for every block result still in the pipe
  assign inflight  = FIFO_CNT_W'(a_valid & a_end & ~a_clear) + FIFO_CNT_W'(b_valid)
                   + FIFO_CNT_W'(c_valid);
  assign committed = fifo_status.count + inflight;
  assign samples.ready = committed < FIFO_CNT_W'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_clear <= 1'b0;
      a_end   <= 1'b0;
      count   <= '0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        if (!cfg.detect_enable) begin
          a_clear <= 1'b1;
          a_end   <= 1'b0;
          count   <= '0;
        end else begin
          a_clear <= 1'b0;
          a_end   <= block_end;
          count   <= block_end ? '0 : count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_sq    <= sq_full[SQ_W-1:0];
      a_count <= count_inc;
      a_time  <= samples.time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      b_valid <= a_valid & a_end & ~a_clear;
      c_valid <= b_valid;
      if (a_valid) begin
        if (a_clear || a_end) begin
          acc <= '0;
        end else begin
          acc <= acc_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    b_sum   <= acc_sum;
    b_prod  <= prod;
    b_time  <= a_time;
    c_above <= PROD_W'(b_sum) >= b_prod;
    c_time  <= b_time;
  end

  assign push              = c_valid;
  assign push_data.above   = c_above;
  assign push_data.time_ms = c_time;

  `BRSD_ASSERT(a_no_overbook, clk, rst,
               (fifo_status.count + inflight) <= FIFO_CNT_W'(FIFO_DEPTH))
  `BRSD_ASSERT_NEXT(a_clear_drops_sum, clk, rst, a_valid && a_clear, acc == '0)

endmodule

// ----- hdl/brsd_fifo.sv -----
// Short queue of evaluated blocks between the front and the debounce stage.
`timescale 1ns / 1ps
`include "block_rms_signal_detector_unit_defines.svh"
module brsd_fifo import brsd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  block_event_t  push_data,
  input  logic          pop,
  output block_event_t  head,
  output fifo_status_t  status
);

  block_event_t          entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + FIFO_CNT_W'(1);
        2'b01:   count <= count - FIFO_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  assign head         = entries[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);

  `BRSD_ASSERT(a_no_push_full, clk, rst, !push || (count != FIFO_CNT_W'(FIFO_DEPTH)))
  `BRSD_ASSERT(a_no_pop_empty, clk, rst, !pop || (count != '0))

endmodule

// ----- hdl/brsd_back.sv -----
// Back end: attack/release debounce of the present flag and result register.
`timescale 1ns / 1ps
`include "block_rms_signal_detector_unit_defines.svh"
module brsd_back import brsd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  block_event_t  head,
  input  fifo_status_t  fifo_status,
  output logic          pop,
  brsd_result_if.source results
);

  logic              present_flag;
  logic              cand_valid;
  logic              cand_level;
  logic [TIME_W-1:0] cand_start_ms;

  logic [TIME_W-1:0] elapsed;
  logic [MS_W-1:0]   need;
  logic              present_next;
  logic              cand_valid_next;
  logic              changed;

  assign pop     = !fifo_status.empty && (!results.valid || results.ready);
  assign elapsed = head.time_ms - cand_start_ms;
  assign need    = head.above ? cfg.attack_ms : cfg.release_ms;

  always_comb begin
    present_next    = present_flag;
    cand_valid_next = cand_valid;
    changed         = 1'b0;
    if (head.above == present_flag) begin
      cand_valid_next = 1'b0;
    end else if (!cand_valid || cand_level != head.above) begin
      cand_valid_next = 1'b1;
    end else if (elapsed >= TIME_W'(need)) begin
      present_next    = head.above;
      cand_valid_next = 1'b0;
      changed         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present_flag  <= 1'b0;
      cand_valid    <= 1'b0;
      cand_level    <= 1'b0;
      cand_start_ms <= '0;
      results.valid <= 1'b0;
    end else begin
      if (pop) begin
        present_flag <= present_next;
        cand_valid   <= cand_valid_next;
        // arm a fresh candidate
        if (head.above != present_flag && (!cand_valid || cand_level != head.above)) begin
          cand_level    <= head.above;
          cand_start_ms <= head.time_ms;
        end
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      results.signal_present <= present_next;
      results.signal_changed <= changed;
      results.level_above    <= head.above;
    end
  end

  `BRSD_ASSERT(a_change_follows_level, clk, rst,
               !(results.valid && results.signal_changed)
               || (results.signal_present == results.level_above))

endmodule

// ----- hdl/block_rms_signal_detector_unit.sv -----
// Top level of the block RMS signal detector with attack/release debounce.
`timescale 1ns / 1ps
// Usage:
//   samples  - request channel of PCM samples (sample, last_of_block, time_ms).
//   results  - one request per evaluated block: signal_present, signal_changed,
//              level_above. Samples that do not end a block give no result.
//   write_*  - register writes, index 0..3 = detect_enable, threshold_mean_square,
//              attack_ms, release_ms. Write only while the block is idle.
// Throughput is one sample per cycle while samples.ready is high. A block result
// reaches results after its last sample is accepted: square, accumulate and scale
// the threshold, compare, queue, then the debounce stage loads the output register.
// An eight-entry queue sits between the comparison pipeline and the debounce
// stage; samples.ready drops only while eight block results are queued or in
// the pipe, so a stalled receiver holds the front after nine blocks (eight
// queued, one waiting in the output register) and ordinary samples keep
// streaming until then.
// Reset (synchronous, rst high) clears the block sums, the present flag and
// any pending transition, empties the queue and restores register defaults.
// With detect_enable low, samples are taken and dropped, and the partial block
// is discarded; the debounce state is held.
module block_rms_signal_detector_unit import brsd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  brsd_sample_if.sink             samples,
  brsd_result_if.source           results,
  input  logic                    write_enable,
  input  logic [CFG_INDEX_W-1:0]  write_index,
  input  logic [CFG_DATA_W-1:0]   write_data
);

  cfg_t         cfg;
  logic         push;
  block_event_t push_data;
  logic         pop;
  block_event_t head;
  fifo_status_t fifo_status;

  // register file; values are masked to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_enable         <= 1'b1;
      cfg.threshold_mean_square <= THR_W'(1073);
      cfg.attack_ms             <= MS_W'(100);
      cfg.release_ms            <= MS_W'(2000);
    end else if (write_enable) begin
      case (reg_index_t'(write_index))
        REG_DETECT_ENABLE: cfg.detect_enable         <= write_data[0];
        REG_THRESHOLD:     cfg.threshold_mean_square <= write_data[THR_W-1:0];
        REG_ATTACK_MS:     cfg.attack_ms             <= write_data[MS_W-1:0];
        REG_RELEASE_MS:    cfg.release_ms            <= write_data[MS_W-1:0];
        default:           cfg                       <= cfg;
      endcase
    end
  end

  // accept samples and classify each finished block as above or below
  brsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .samples     (samples),
    .fifo_status (fifo_status),
    .push        (push),
    .push_data   (push_data)
  );

  // decouple the comparison pipeline from a stalled receiver
  brsd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (fifo_status)
  );

  // debounce and drive the result register
  brsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .fifo_status (fifo_status),
    .pop         (pop),
    .results     (results)
  );

endmodule

// ----- tb/block_rms_detector_checker.sv -----
// Checker: watches sample and result requests, predicts each block verdict and compares.
`timescale 1ns / 1ps
module block_rms_detector_checker import brsd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  brsd_sample_if                 samples,
  brsd_result_if                 results,
  input  logic                   write_enable,
  input  logic [CFG_INDEX_W-1:0] write_index,
  input  logic [CFG_DATA_W-1:0]  write_data,
  output int                     failures,
  output int                     verdicts_due,
  output int                     blocks_checked,
  output int                     flag_changes
);

  typedef struct packed {
    logic present;
    logic changed;
    logic above;
  } verdict_t;

  verdict_t           verdict_q[$];
  cfg_t               cfg;
  logic [SUM_W-1:0]   energy;
  logic [COUNT_W-1:0] n_samples;
  logic               present;
  logic               armed;
  logic               armed_level;
  logic [TIME_W-1:0]  armed_since;
  int                 fail_n;
  int                 checked_n;
  int                 change_n;

  // Accumulate one sample; at a block end, decide the level and run the debounce.
  task automatic take_sample(input logic signed [15:0] s, input logic last,
                             input logic [TIME_W-1:0] now);
    logic [15:0]       mag;
    logic [SQ_W-1:0]   sq;
    logic [PROD_W-1:0] floor_sum;
    logic [TIME_W-1:0] elapsed;
    logic [MS_W-1:0]   need;
    verdict_t          v;
    if (!cfg.detect_enable) begin
      energy = '0;
      n_samples = '0;
    end else begin
      mag = s[15] ? 16'(-s) : 16'(s);
      sq = SQ_W'(mag) * SQ_W'(mag);
      energy = energy + SUM_W'(sq);
      n_samples = n_samples + 1'b1;
      if (last || n_samples == COUNT_W'(MAX_BLOCK_SAMPLES)) begin
        floor_sum = PROD_W'(cfg.threshold_mean_square) * PROD_W'(n_samples);
        v.above = (energy >= floor_sum);
        v.changed = 1'b0;
        energy = '0;
        n_samples = '0;
        if (v.above == present) begin
          armed = 1'b0;
        end else if (!armed || armed_level != v.above) begin
          armed = 1'b1;
          armed_level = v.above;
          armed_since = now;
        end else begin
          need = v.above ? cfg.attack_ms : cfg.release_ms;
          elapsed = now - armed_since;
          if (elapsed >= TIME_W'(need)) begin
            present = v.above;
            armed = 1'b0;
            v.changed = 1'b1;
          end
        end
        v.present = present;
        verdict_q.push_back(v);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst) begin
      // register defaults after reset
      cfg.detect_enable = 1'b1;
      cfg.threshold_mean_square = THR_W'(1073);
      cfg.attack_ms = MS_W'(100);
      cfg.release_ms = MS_W'(2000);
      energy = '0;
      n_samples = '0;
      present = 1'b0;
      armed = 1'b0;
      armed_level = 1'b0;
      armed_since = '0;
      verdict_q.delete();
    end else begin
      if (write_enable) begin
        case (reg_index_t'(write_index))
          REG_DETECT_ENABLE: cfg.detect_enable = write_data[0];
          REG_THRESHOLD:     cfg.threshold_mean_square = write_data[THR_W-1:0];
          REG_ATTACK_MS:     cfg.attack_ms = write_data[MS_W-1:0];
          REG_RELEASE_MS:    cfg.release_ms = write_data[MS_W-1:0];
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result: signal_present %0d signal_changed %0d level_above %0d",
                 results.signal_present, results.signal_changed, results.level_above);
          fail_n++;
        end else begin
          want = verdict_q.pop_front();
          checked_n++;
          if (want.changed) change_n++;
          if (results.signal_present !== want.present) begin
            $error("signal_present: expected %0d, got %0d", want.present,
                   results.signal_present);
            fail_n++;
          end
          if (results.signal_changed !== want.changed) begin
            $error("signal_changed: expected %0d, got %0d", want.changed,
                   results.signal_changed);
            fail_n++;
          end
          if (results.level_above !== want.above) begin
            $error("level_above: expected %0d, got %0d", want.above, results.level_above);
            fail_n++;
          end
        end
      end
      if (samples.valid && samples.ready)
        take_sample(samples.sample, samples.last_of_block, samples.time_ms);
    end
    failures <= fail_n;
    verdicts_due <= verdict_q.size();
    blocks_checked <= checked_n;
    flag_changes <= change_n;
  end

endmodule

// ----- tb/block_rms_signal_detector_unit_tb.sv -----
// Testbench top: drives samples and register writes, stalls results, reports the verdict.
`timescale 1ns / 1ps
module block_rms_signal_detector_unit_tb;
  import brsd_pkg::*;

  // Cap on the whole run; the slowest legal run needs far fewer cycles.
  localparam int LIMIT_CYCLES = 900_000;
  // Cycles to let the pipe empty of blocks that give no result before a write.
  localparam int SETTLE_CYCLES = 12;
  // Long receiver hold-off that fills the result queue and stalls samples.
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_SAMPLES = 1600;

  typedef enum {LVL_LOUD, LVL_QUIET, LVL_NOISE} level_kind_t;

  logic                   clk;
  logic                   rst;
  logic                   write_enable;
  logic [CFG_INDEX_W-1:0] write_index;
  logic [CFG_DATA_W-1:0]  write_data;

  brsd_sample_if samp ();
  brsd_result_if res ();

  int failures;
  int verdicts_due;
  int blocks_checked;
  int flag_changes;

  // Stimulus knobs shared between the sender and the receiver.
  int          tx_gap_pct;
  int          rx_stall_pct;
  bit          hold_req;
  bit          sensing_on;
  int          samples_sent;
  int          settings_n;
  int          amp;
  int unsigned span;
  logic [31:0] now_ms;
  int          cycle_count;

  block_rms_signal_detector_unit dut (
    .clk          (clk),
    .rst          (rst),
    .samples      (samp),
    .results      (res),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  block_rms_detector_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .samples        (samp),
    .results        (res),
    .write_enable   (write_enable),
    .write_index    (write_index),
    .write_data     (write_data),
    .failures       (failures),
    .verdicts_due   (verdicts_due),
    .blocks_checked (blocks_checked),
    .flag_changes   (flag_changes)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Write all four registers on consecutive edges; hold write_enable high throughout
  // so it only drops once, after the last write.
  task automatic configure(input logic en, input int unsigned thr, input int unsigned att,
                           input int unsigned rel);
    write_enable <= 1'b1;
    write_index <= REG_DETECT_ENABLE;
    write_data <= CFG_DATA_W'(en);
    @(posedge clk);
    write_index <= REG_THRESHOLD;
    write_data <= CFG_DATA_W'(thr);
    @(posedge clk);
    write_index <= REG_ATTACK_MS;
    write_data <= CFG_DATA_W'(att);
    @(posedge clk);
    write_index <= REG_RELEASE_MS;
    write_data <= CFG_DATA_W'(rel);
    @(posedge clk);
    write_enable <= 1'b0;
    sensing_on = en;
    settings_n++;
  endtask

  // Offer one sample request and hold it until accepted; then maybe idle a burst.
  task automatic send_sample(input logic signed [15:0] s, input logic last,
                             input logic [31:0] t);
    samp.valid <= 1'b1;
    samp.sample <= s;
    samp.last_of_block <= last;
    samp.time_ms <= t;
    do @(posedge clk); while (!samp.ready);
    if (sensing_on) samples_sent++;
    if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
      samp.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // One whole block. Loud samples sit at or above the threshold amplitude and
  // quiet ones below it, so the block level follows the kind; noise is anything.
  task automatic send_block(input level_kind_t kind, input int len);
    int mag;
    logic signed [15:0] s;
    now_ms += $urandom_range(0, span);
    for (int i = 0; i < len; i++) begin
      case (kind)
        LVL_LOUD:  mag = $urandom_range(amp, 32767);
        LVL_QUIET: mag = (amp == 0) ? 0 : $urandom_range(0, amp - 1);
        default:   mag = $urandom_range(0, 32768);
      endcase
      if (kind == LVL_LOUD && $urandom_range(0, 15) == 0) mag = 32768;
      s = 16'(($urandom_range(0, 1) != 0) ? -mag : mag);
      send_sample(s, i == len - 1, (i == len - 1) ? now_ms : $urandom);
    end
  endtask

  // Drop valid, wait for every predicted result, then let the pipe settle.
  task automatic drain();
    samp.valid <= 1'b0;
    do @(posedge clk); while (verdicts_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int unsigned pick_ms();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 16'hFFFF;
      2:       return $urandom_range(0, 16'hFFFF);
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  // Receiver: random stall bursts, plus one long hold-off when requested.
  initial begin
    res.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        res.ready <= 1'b1;
        hold_req = 1'b0;
      end else if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        res.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if it never drains.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned thr;
    int unsigned att;
    int unsigned rel;
    int          base;
    int          phase_end;
    int          run_len;
    int          len;
    level_kind_t level;

    rst <= 1'b1;
    write_enable <= 1'b0;
    write_index <= REG_DETECT_ENABLE;
    write_data <= '0;
    samp.valid <= 1'b0;
    samp.sample <= '0;
    samp.last_of_block <= 1'b0;
    samp.time_ms <= '0;
    tx_gap_pct = 20;
    rx_stall_pct = 20;
    hold_req = 1'b0;
    sensing_on = 1'b1;
    samples_sent = 0;
    settings_n = 0;
    amp = 1000;
    span = 2;
    now_ms = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero attack/release: the first disagreeing block only arms, the second commits.
    // Then a crossing back to the current side cancels a pending rise.
    configure(1'b1, 1073, 0, 0);
    send_sample(16'sh7FFF, 1'b1, 32'd10);
    send_sample(16'sh8000, 1'b1, 32'd10);
    send_sample(16'sh0000, 1'b1, 32'd20);
    send_sample(16'sh0000, 1'b0, $urandom);
    send_sample(16'sh0001, 1'b1, 32'd20);
    send_sample(16'sh7FFF, 1'b1, 32'd30);
    send_sample(16'sh0000, 1'b1, 32'd31);
    send_sample(16'sh7FFF, 1'b1, 32'd32);
    drain();

    // Full-scale threshold and maximum attack, timed across the 32-bit wrap:
    // one short of the attack holds, exactly the attack commits.
    configure(1'b1, 1 << 30, 16'hFFFF, 16'hFFFF);
    send_sample(16'sh8000, 1'b0, $urandom);
    send_sample(16'sh8000, 1'b1, 32'hFFFF_FFF0);
    send_sample(16'sh7FFF, 1'b1, 32'hFFFF_FFF8);
    send_sample(16'sh8000, 1'b1, 32'hFFFF_FFF0);
    send_sample(16'sh8000, 1'b1, 32'h0000_FFEE);
    send_sample(16'sh8000, 1'b1, 32'h0000_FFEF);
    drain();

    // Zero threshold: even silence counts as above.
    configure(1'b1, 0, 0, 16'hFFFF);
    send_sample(16'sh0000, 1'b1, 32'd5);
    send_sample(16'sh5555, 1'b1, 32'd6);
    send_sample(16'shAAAA, 1'b1, 32'd7);
    drain();

    // Sensing off drops a block under way and holds the debounce state.
    tx_gap_pct = 15;
    rx_stall_pct = 15;
    configure(1'b1, 1073, 50, 50);
    send_sample(16'sh7000, 1'b0, $urandom);
    send_sample(16'sh9000, 1'b0, $urandom);
    send_sample(16'sh7FFF, 1'b0, $urandom);
    drain();
    configure(1'b0, 1073, 50, 50);
    repeat (10) send_sample(16'($urandom), 1'($urandom), $urandom);
    drain();
    configure(1'b1, 1073, 50, 50);
    send_sample(16'sh0001, 1'b1, 32'd200);
    drain();

    // Back-pressure: hold the receiver off while single-sample blocks keep coming,
    // so the result queue fills and the block stalls its sample input.
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    amp = 2000;
    span = 3;
    configure(1'b1, amp * amp, 4, 4);
    hold_req = 1'b1;
    level = LVL_LOUD;
    for (int i = 0; i < 40; i++) begin
      send_block(level, 1);
      if (i % 3 == 2) level = (level == LVL_LOUD) ? LVL_QUIET : LVL_LOUD;
    end
    drain();

    // Random phases: runs of loud and quiet blocks with random content, some noise
    // blocks and time jumps, a fresh register setting per phase.
    base = samples_sent;
    while (samples_sent - base < RANDOM_SAMPLES) begin
      if (samples_sent - base > RANDOM_SAMPLES - 300) begin
        // advance without idling at the end of the run
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        rx_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      amp = $urandom_range(1, 32767);
      thr = amp * amp;
      case ($urandom_range(0, 9))
        0: begin
          amp = 0;
          thr = 0;
        end
        1: thr = $urandom_range(0, 1 << 30);
        default: ;
      endcase
      att = pick_ms();
      rel = pick_ms();
      span = ((att > rel) ? att : rel) / 3 + 2;
      if ($urandom_range(0, 7) == 0) begin
        configure(1'b0, thr, att, rel);
        repeat ($urandom_range(3, 20)) send_sample(16'($urandom), 1'($urandom), $urandom);
        drain();
      end
      configure(1'b1, thr, att, rel);
      if ($urandom_range(0, 3) == 0) now_ms = $urandom;
      phase_end = samples_sent + $urandom_range(30, 150);
      level = ($urandom_range(0, 1) != 0) ? LVL_LOUD : LVL_QUIET;
      while (samples_sent < phase_end) begin
        run_len = $urandom_range(1, 8);
        repeat (run_len) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
          send_block(($urandom_range(0, 5) == 0) ? LVL_NOISE : level, len);
          if ($urandom_range(0, 49) == 0) now_ms = $urandom;
        end
        level = (level == LVL_LOUD) ? LVL_QUIET : LVL_LOUD;
      end
      drain();
    end

    $display("Run: %0d samples, %0d block results, %0d flag changes, %0d register settings.",
             samples_sent, blocks_checked, flag_changes, settings_n);
    $display("Included zero and full-scale thresholds, sensing off, time wrap and a long result stall.");
    if (failures == 0 && verdicts_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
